@@ design/sorted_offset_floor_search_table_defines.svh @@
// Assertion macros shared by the checker of the offset floor search table.
// No dependencies; include by bare file name.
`ifndef SORTED_OFFSET_FLOOR_SEARCH_TABLE_DEFINES_SVH
`define SORTED_OFFSET_FLOOR_SEARCH_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SOFST_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SOFST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/sofst_pkg.sv @@
// Types and codes of the offset floor search table.
// No dependencies; imported by every module of the block.
package sofst_pkg;

  localparam logic [2:0] REQ_CLEAR  = 3'd0;
  localparam logic [2:0] REQ_APPEND = 3'd1;
  localparam logic [2:0] REQ_FLOOR  = 3'd2;
  localparam logic [2:0] REQ_READ   = 3'd3;
  localparam logic [2:0] REQ_NEXT   = 3'd4;
  localparam logic [2:0] REQ_PREV   = 3'd5;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_FIRST = 6'b000010,
    S_LAST  = 6'b000100,
    S_PROBE = 6'b001000,
    S_FVAL  = 6'b010000,
    S_RDOUT = 6'b100000
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic le;
  } range_ctl_t;

endpackage

@@ design/sofst_range.sv @@
// Bisection bounds of the floor search: lo/hi registers and next probe index.
// Depends on sofst_pkg.
module sofst_range #(
  parameter int IDX_W = 12
) (
  input  logic                   clk,
  input  sofst_pkg::range_ctl_t  ctl,
  input  logic [IDX_W-1:0]       top_idx,
  output logic [IDX_W-1:0]       probe_idx,
  output logic [IDX_W-1:0]       floor_idx,
  output logic                   more
);
  import sofst_pkg::*;

  logic [IDX_W-1:0] lo_r;
  logic [IDX_W-1:0] hi_r;
  logic [IDX_W-1:0] lo_nxt;
  logic [IDX_W-1:0] hi_nxt;
  logic [IDX_W-1:0] mid_cur;

  always_comb begin
    mid_cur = lo_r + ((hi_r - lo_r) >> 1);
    lo_nxt  = lo_r;
    hi_nxt  = hi_r;
    if (ctl.load) begin
      lo_nxt = '0;
      hi_nxt = top_idx;
    end else if (ctl.step) begin
      if (ctl.le) begin
        lo_nxt = mid_cur;
      end else begin
        hi_nxt = mid_cur;
      end
    end
  end

  assign probe_idx = lo_nxt + ((hi_nxt - lo_nxt) >> 1);
  assign floor_idx = lo_nxt;
  assign more      = (({1'b0, lo_nxt} + (IDX_W+1)'(1)) < {1'b0, hi_nxt});

  always_ff @(posedge clk) begin
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
  end

endmodule

@@ design/sorted_offset_floor_search_table.sv @@
// Top level of the offset floor search table: command port, table memory, sequencer.
// Depends on sofst_pkg and sofst_range.
//
// Usage:
//   A transaction is accepted at a clock edge where start is high and busy low.
//   in_req_type selects clear, append, floor search, read at index, next or
//   previous; in_offset is the key or value, in_index the read index.
//   Each transaction gives one result, shown for one cycle with out_valid.
//   The receiver cannot stall: results must be taken when out_valid is high.
// Sequence from acceptance to the out_valid cycle:
//   clear, append, misses found at issue: result in the next cycle, busy stays low.
//   read at index: one table read, result from S_RDOUT.
//   floor, next, previous: S_FIRST checks the first entry; a key at or below it
//   goes to S_FVAL, else S_LAST checks the last entry and, for a key below it,
//   S_PROBE bisects (about log2(entries) probes) before S_FVAL; next or previous
//   that steps to a neighbor entry reads it in S_RDOUT; each probe is a memory read.
// Reset clears the entry count and the sequencer; table contents are kept
// and are read only below the entry count. No clearing pass is needed.
module sorted_offset_floor_search_table #(
  parameter int TABLE_DEPTH = 4096,
  parameter int OFFSET_BITS = 48
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [2:0]                        in_req_type,
  input  logic [OFFSET_BITS-1:0]            in_offset,
  input  logic [$clog2(TABLE_DEPTH)-1:0]    in_index,
  output logic                              out_valid,
  output logic [$clog2(TABLE_DEPTH)-1:0]    out_found_index,
  output logic [OFFSET_BITS-1:0]            out_found_offset,
  output logic                              out_hit,
  output logic [1:0]                        out_status,
  output logic [$clog2(TABLE_DEPTH):0]      out_entry_total
);
  import sofst_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = IDX_W + 1;

  logic [OFFSET_BITS-1:0] mem [TABLE_DEPTH];
  logic [OFFSET_BITS-1:0] rd_data_r;

  state_t                 state_r, state_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [OFFSET_BITS-1:0] key_r, key_nxt;
  logic [2:0]             req_r, req_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;

  logic                   out_valid_r;
  logic [IDX_W-1:0]       out_idx_r;
  logic [OFFSET_BITS-1:0] out_off_r;
  logic                   out_hit_r;
  logic [1:0]             out_status_r;

  logic                   emit;
  logic [IDX_W-1:0]       em_idx;
  logic [OFFSET_BITS-1:0] em_off;
  logic                   em_hit;
  logic [1:0]             em_status;

  logic                   wr_en;
  logic                   rd_en;
  logic [IDX_W-1:0]       rd_addr;

  range_ctl_t             rctl;
  logic [IDX_W-1:0]       probe_idx;
  logic [IDX_W-1:0]       floor_idx;
  logic                   more;
  logic [IDX_W-1:0]       hi_last;

  assign busy    = (state_r != S_IDLE);
  assign hi_last = IDX_W'(count_r - CNT_W'(1));

  sofst_range #(.IDX_W(IDX_W)) u_range (
    .clk       (clk),
    .ctl       (rctl),
    .top_idx   (hi_last),
    .probe_idx (probe_idx),
    .floor_idx (floor_idx),
    .more      (more)
  );

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    key_nxt   = key_r;
    req_nxt   = req_r;
    idx_nxt   = idx_r;
    emit      = 1'b0;
    em_idx    = '0;
    em_off    = '0;
    em_hit    = 1'b0;
    em_status = ST_MISS;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = '0;
    rctl      = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          key_nxt = in_offset;
          req_nxt = in_req_type;
          case (in_req_type)
            REQ_CLEAR: begin
              count_nxt = '0;
              emit      = 1'b1;
              em_status = ST_OK;
            end
            REQ_APPEND: begin
              emit = 1'b1;
              if (count_r == CNT_W'(TABLE_DEPTH)) begin
                em_status = ST_FULL;
              end else begin
                wr_en     = 1'b1;
                count_nxt = count_r + CNT_W'(1);
                em_idx    = count_r[IDX_W-1:0];
                em_off    = in_offset;
                em_hit    = 1'b1;
                em_status = ST_OK;
              end
            end
            REQ_FLOOR, REQ_NEXT, REQ_PREV: begin
              if (count_r == '0) begin
                emit = 1'b1;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = '0;
                state_nxt = S_FIRST;
              end
            end
            REQ_READ: begin
              if ({1'b0, in_index} >= count_r) begin
                emit = 1'b1;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = in_index;
                idx_nxt   = in_index;
                state_nxt = S_RDOUT;
              end
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      S_FIRST: begin
        rd_en = 1'b1;
        if (key_r <= rd_data_r) begin
          idx_nxt   = '0;
          rd_addr   = '0;
          state_nxt = S_FVAL;
        end else begin
          rd_addr   = hi_last;
          state_nxt = S_LAST;
        end
      end
      S_LAST: begin
        rd_en = 1'b1;
        if (key_r >= rd_data_r) begin
          idx_nxt   = hi_last;
          rd_addr   = hi_last;
          state_nxt = S_FVAL;
        end else begin
          rctl.load = 1'b1;
          if (more) begin
            rd_addr   = probe_idx;
            state_nxt = S_PROBE;
          end else begin
            idx_nxt   = floor_idx;
            rd_addr   = floor_idx;
            state_nxt = S_FVAL;
          end
        end
      end
      S_PROBE: begin
        rd_en     = 1'b1;
        rctl.step = 1'b1;
        rctl.le   = (rd_data_r <= key_r);
        if (more) begin
          rd_addr = probe_idx;
        end else begin
          idx_nxt   = floor_idx;
          rd_addr   = floor_idx;
          state_nxt = S_FVAL;
        end
      end
      S_FVAL: begin
        state_nxt = S_IDLE;
        em_idx    = idx_r;
        em_off    = rd_data_r;
        em_hit    = 1'b1;
        em_status = ST_OK;
        case (req_r)
          REQ_NEXT: begin
            if (rd_data_r == key_r) begin
              if (({1'b0, idx_r} + CNT_W'(1)) >= count_r) begin
                emit      = 1'b1;
                em_idx    = '0;
                em_off    = '0;
                em_hit    = 1'b0;
                em_status = ST_MISS;
              end else begin
                idx_nxt   = idx_r + IDX_W'(1);
                rd_en     = 1'b1;
                rd_addr   = idx_r + IDX_W'(1);
                state_nxt = S_RDOUT;
              end
            end else begin
              emit = 1'b1;
            end
          end
          REQ_PREV: begin
            if (idx_r != '0) begin
              idx_nxt   = idx_r - IDX_W'(1);
              rd_en     = 1'b1;
              rd_addr   = idx_r - IDX_W'(1);
              state_nxt = S_RDOUT;
            end else begin
              emit = 1'b1;
            end
          end
          default: begin
            emit = 1'b1;
          end
        endcase
      end
      S_RDOUT: begin
        emit      = 1'b1;
        em_idx    = idx_r;
        em_off    = rd_data_r;
        em_hit    = 1'b1;
        em_status = ST_OK;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[IDX_W-1:0]] <= in_offset;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    req_r <= req_nxt;
    idx_r <= idx_nxt;
    if (emit) begin
      out_idx_r    <= em_idx;
      out_off_r    <= em_off;
      out_hit_r    <= em_hit;
      out_status_r <= em_status;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_found_index  = out_idx_r;
  assign out_found_offset = out_off_r;
  assign out_hit          = out_hit_r;
  assign out_status       = out_status_r;
  assign out_entry_total  = count_r;

endmodule

@@ design/sofst_check.sv @@
// Port-level checker of the offset floor search table, with its bind.
// Depends on sofst_pkg and sorted_offset_floor_search_table_defines.svh.
`include "sorted_offset_floor_search_table_defines.svh"

module sofst_check #(
  parameter int TABLE_DEPTH = 4096,
  parameter int OFFSET_BITS = 48
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic [2:0]                        in_req_type,
  input logic                              out_valid,
  input logic [$clog2(TABLE_DEPTH)-1:0]    out_found_index,
  input logic [OFFSET_BITS-1:0]            out_found_offset,
  input logic                              out_hit,
  input logic [1:0]                        out_status,
  input logic [$clog2(TABLE_DEPTH):0]      out_entry_total
);
  import sofst_pkg::*;

  `SOFST_ASSERT_NOW(a_miss_zero, out_valid && !out_hit, out_found_index == '0 && out_found_offset == '0, "miss with nonzero fields")
  `SOFST_ASSERT_NOW(a_hit_ok, out_valid && out_hit, out_status == ST_OK, "hit with bad status")
  `SOFST_ASSERT_NEXT(a_clear, start && !busy && in_req_type == REQ_CLEAR, out_valid && out_entry_total == '0 && !out_hit, "clear transaction result wrong")
  `SOFST_ASSERT_NOW(a_done_result, $fell(busy), out_valid, "busy dropped without a result")

endmodule

bind sorted_offset_floor_search_table sofst_check #(
  .TABLE_DEPTH (TABLE_DEPTH),
  .OFFSET_BITS (OFFSET_BITS)
) u_sofst_check (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_req_type      (in_req_type),
  .out_valid        (out_valid),
  .out_found_index  (out_found_index),
  .out_found_offset (out_found_offset),
  .out_hit          (out_hit),
  .out_status       (out_status),
  .out_entry_total  (out_entry_total)
);

@@ verif/sorted_offset_floor_search_table_tb.sv @@
// Testbench for the offset floor search table: directed and random transactions checked
// against an in-bench prediction of the table. Depends on sofst_pkg and the block's top level.
`timescale 1ns / 100ps

module sorted_offset_floor_search_table_tb;
  import sofst_pkg::*;

  localparam int DEPTH = 4096;
  localparam int IDX_W = 12;
  localparam int OFF_W = 48;
  localparam int RANDOM_ITEMS = 1800;
  localparam int DRAIN_CYCLES = 24;
  localparam logic [OFF_W-1:0] MAX_OFFSET = 48'hFFFF_FFFF_FFFF;
  localparam logic [2:0] REQ_UNDEF_LO = 3'd6;
  localparam logic [2:0] REQ_UNDEF_HI = 3'd7;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [OFF_W-1:0] off;
    logic             hit;
    logic [1:0]       status;
    logic [IDX_W:0]   total;
  } lookup_result_t;

  typedef struct {
    logic [2:0]       req;
    logic [OFF_W-1:0] key;
    logic [IDX_W-1:0] rd;
    bit               typed;
    lookup_result_t   want;
  } directed_row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [2:0]       in_req_type = REQ_CLEAR;
  logic [OFF_W-1:0] in_offset = '0;
  logic [IDX_W-1:0] in_index = '0;
  logic             out_valid;
  logic [IDX_W-1:0] out_found_index;
  logic [OFF_W-1:0] out_found_offset;
  logic             out_hit;
  logic [1:0]       out_status;
  logic [IDX_W:0]   out_entry_total;

  logic [OFF_W-1:0] line_starts [DEPTH];
  int unsigned      line_total = 0;
  lookup_result_t   pending_lookups[$];
  directed_row_t    directed_rows[$];

  int mismatches = 0;
  int results_seen = 0;
  int sent_total = 0;
  int random_sent = 0;
  bit tally_random = 1'b0;
  int burst_left = 0;
  int unsigned peak_total = 0;
  int full_rejects = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sorted_offset_floor_search_table u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_req_type      (in_req_type),
    .in_offset        (in_offset),
    .in_index         (in_index),
    .out_valid        (out_valid),
    .out_found_index  (out_found_index),
    .out_found_offset (out_found_offset),
    .out_hit          (out_hit),
    .out_status       (out_status),
    .out_entry_total  (out_entry_total)
  );

  function automatic logic [OFF_W-1:0] rand_offset();
    return {16'($urandom()), 32'($urandom())};
  endfunction

  function automatic logic [IDX_W-1:0] rand_index();
    return IDX_W'($urandom_range(0, DEPTH - 1));
  endfunction

  function automatic int unsigned floor_slot(input logic [OFF_W-1:0] key);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lo = 0;
    hi = line_total - 1;
    if (key <= line_starts[0]) return 0;
    if (key >= line_starts[hi]) return hi;
    while (lo + 1 < hi) begin
      mid = lo + (hi - lo) / 2;
      if (line_starts[mid] <= key) lo = mid;
      else hi = mid;
    end
    return lo;
  endfunction

  // Update the table copy and return the result one transaction should produce.
  function automatic lookup_result_t predict_lookup(input logic [2:0] req,
                                                    input logic [OFF_W-1:0] key,
                                                    input logic [IDX_W-1:0] rd);
    lookup_result_t r;
    int unsigned slot;
    bit found;
    r = '0;
    r.status = ST_MISS;
    found = 1'b0;
    slot = 0;
    case (req)
      REQ_CLEAR: begin
        line_total = 0;
        r.status = ST_OK;
      end
      REQ_APPEND: begin
        if (line_total >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          slot = line_total;
          line_starts[slot] = key;
          line_total++;
          found = 1'b1;
        end
      end
      REQ_FLOOR: begin
        if (line_total != 0) begin
          slot = floor_slot(key);
          found = 1'b1;
        end
      end
      REQ_READ: begin
        if (rd < line_total) begin
          slot = 32'(rd);
          found = 1'b1;
        end
      end
      REQ_NEXT: begin
        if (line_total != 0) begin
          slot = floor_slot(key);
          if (line_starts[slot] == key) slot++;
          found = (slot < line_total);
        end
      end
      REQ_PREV: begin
        if (line_total != 0) begin
          slot = floor_slot(key);
          if (slot > 0) slot--;
          found = 1'b1;
        end
      end
      default: ;
    endcase
    if (found) begin
      r.idx = IDX_W'(slot);
      r.off = line_starts[slot];
      r.hit = 1'b1;
      r.status = ST_OK;
    end
    r.total = (IDX_W + 1)'(line_total);
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst_left = $urandom_range(10, 60);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 18);
    return $urandom_range(19, 60);
  endfunction

  task automatic transact(input logic [2:0] req, input logic [OFF_W-1:0] key,
                          input logic [IDX_W-1:0] rd);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_req_type <= req;
    in_offset <= key;
    in_index <= rd;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_lookups.push_back(predict_lookup(req, key, rd));
    if (pending_lookups[$].status == ST_FULL) full_rejects++;
    if (line_total > peak_total) peak_total = line_total;
    sent_total++;
    if (tally_random) random_sent++;
  endtask

  // Append n offsets, mostly ascending from the current last entry, a few out of order.
  task automatic append_run(input int n);
    logic [OFF_W-1:0] tail;
    logic [OFF_W-1:0] stride;
    logic [OFF_W-1:0] val;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: stride = '0;
        1: stride = OFF_W'(1);
        2: stride = rand_offset() >> $urandom_range(8, 47);
        default: stride = OFF_W'($urandom_range(2, 5000));
      endcase
      if (line_total == 0) begin
        val = rand_offset() >> $urandom_range(0, 47);
      end else begin
        tail = line_starts[line_total - 1];
        val = (tail > MAX_OFFSET - stride) ? MAX_OFFSET : tail + stride;
      end
      if ($urandom_range(0, 24) == 0) val = rand_offset();
      transact(REQ_APPEND, val, rand_index());
    end
  endtask

  task automatic query_burst(input int q);
    logic [OFF_W-1:0] key;
    logic [IDX_W-1:0] rd;
    int unsigned slot;
    int pick;
    for (int i = 0; i < q; i++) begin
      slot = (line_total == 0) ? 0 : $urandom_range(0, line_total - 1);
      key = (line_total == 0) ? rand_offset() : line_starts[slot];
      case ($urandom_range(0, 19))
        6, 7: if (key != 0) key = key - 1;
        8, 9: if (key != MAX_OFFSET) key = key + 1;
        10, 11: begin
          if (slot + 1 < line_total && line_starts[slot + 1] > key)
            key = key + (line_starts[slot + 1] - key) / 2;
        end
        12, 13, 14: key = rand_offset();
        15: key = '0;
        16: key = MAX_OFFSET;
        default: ;
      endcase
      rd = ($urandom_range(0, 9) < 7 && line_total != 0) ? IDX_W'(slot) : rand_index();
      pick = $urandom_range(0, 99);
      if (pick < 25) transact(REQ_FLOOR, key, rand_index());
      else if (pick < 50) transact(REQ_NEXT, key, rand_index());
      else if (pick < 70) transact(REQ_PREV, key, rand_index());
      else if (pick < 90) transact(REQ_READ, rand_offset(), rd);
      else if (pick < 93) transact(pick[0] ? REQ_UNDEF_LO : REQ_UNDEF_HI, key, rd);
      else if (pick < 99) transact(REQ_APPEND, rand_offset(), rd);
      else transact(REQ_CLEAR, key, rd);
    end
  endtask

  task automatic add_row(input logic [2:0] req, input logic [OFF_W-1:0] key,
                         input logic [IDX_W-1:0] rd, input bit typed,
                         input logic [IDX_W-1:0] idx, input logic [OFF_W-1:0] off,
                         input logic hit, input logic [1:0] status,
                         input logic [IDX_W:0] total);
    directed_row_t row;
    row.req = req;
    row.key = key;
    row.rd = rd;
    row.typed = typed;
    row.want = '{idx: idx, off: off, hit: hit, status: status, total: total};
    directed_rows.push_back(row);
  endtask

  task automatic flag_mismatch(input string what, input logic [63:0] want_v,
                               input logic [63:0] got_v);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want_v, got_v);
  endtask

  always @(posedge clk) begin : check_results
    lookup_result_t want;
    if (rst_n && out_valid) begin
      if (pending_lookups.size() == 0) begin
        flag_mismatch("result with nothing pending", 64'd0, 64'd1);
      end else begin
        want = pending_lookups.pop_front();
        results_seen++;
        if (out_found_index !== want.idx)
          flag_mismatch("found_index", 64'(want.idx), 64'(out_found_index));
        if (out_found_offset !== want.off)
          flag_mismatch("found_offset", 64'(want.off), 64'(out_found_offset));
        if (out_hit !== want.hit) flag_mismatch("hit", 64'(want.hit), 64'(out_hit));
        if (out_status !== want.status)
          flag_mismatch("status", 64'(want.status), 64'(out_status));
        if (out_entry_total !== want.total)
          flag_mismatch("entry_total", 64'(want.total), 64'(out_entry_total));
      end
    end
  end

  initial begin
    int n;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    add_row(REQ_FLOOR, '0, '0, 1'b1, '0, '0, 1'b0, ST_MISS, '0);
    add_row(REQ_NEXT, MAX_OFFSET, '0, 1'b1, '0, '0, 1'b0, ST_MISS, '0);
    add_row(REQ_PREV, '0, '0, 1'b1, '0, '0, 1'b0, ST_MISS, '0);
    add_row(REQ_READ, '0, '0, 1'b1, '0, '0, 1'b0, ST_MISS, '0);
    add_row(REQ_UNDEF_LO, 48'd5, 12'd1, 1'b1, '0, '0, 1'b0, ST_MISS, '0);
    add_row(REQ_UNDEF_HI, MAX_OFFSET, 12'hFFF, 1'b1, '0, '0, 1'b0, ST_MISS, '0);
    add_row(REQ_APPEND, '0, 12'hFFF, 1'b1, 12'd0, '0, 1'b1, ST_OK, 13'd1);
    add_row(REQ_APPEND, 48'd100, '0, 1'b1, 12'd1, 48'd100, 1'b1, ST_OK, 13'd2);
    add_row(REQ_APPEND, 48'd200, '0, 1'b1, 12'd2, 48'd200, 1'b1, ST_OK, 13'd3);
    add_row(REQ_APPEND, MAX_OFFSET, '0, 1'b1, 12'd3, MAX_OFFSET, 1'b1, ST_OK, 13'd4);
    add_row(REQ_READ, '0, 12'hFFF, 1'b1, '0, '0, 1'b0, ST_MISS, 13'd4);
    add_row(REQ_READ, '0, 12'd4, 1'b1, '0, '0, 1'b0, ST_MISS, 13'd4);
    add_row(REQ_READ, MAX_OFFSET, 12'd3, 1'b0, '0, '0, 1'b0, ST_OK, '0);
    add_row(REQ_FLOOR, '0, '0, 1'b0, '0, '0, 1'b0, ST_OK, '0);
    add_row(REQ_FLOOR, 48'd150, '0, 1'b0, '0, '0, 1'b0, ST_OK, '0);
    add_row(REQ_FLOOR, MAX_OFFSET, '0, 1'b0, '0, '0, 1'b0, ST_OK, '0);
    add_row(REQ_NEXT, 48'd100, '0, 1'b0, '0, '0, 1'b0, ST_OK, '0);
    add_row(REQ_NEXT, 48'd150, '0, 1'b0, '0, '0, 1'b0, ST_OK, '0);
    add_row(REQ_NEXT, MAX_OFFSET, '0, 1'b0, '0, '0, 1'b0, ST_OK, '0);
    add_row(REQ_PREV, '0, '0, 1'b0, '0, '0, 1'b0, ST_OK, '0);
    add_row(REQ_PREV, 48'd200, '0, 1'b0, '0, '0, 1'b0, ST_OK, '0);
    add_row(REQ_UNDEF_HI, 48'd100, 12'd2, 1'b1, '0, '0, 1'b0, ST_MISS, 13'd4);
    add_row(REQ_CLEAR, MAX_OFFSET, 12'hFFF, 1'b1, '0, '0, 1'b0, ST_OK, '0);
    add_row(REQ_FLOOR, 48'd100, '0, 1'b1, '0, '0, 1'b0, ST_MISS, '0);

    foreach (directed_rows[i]) begin
      transact(directed_rows[i].req, directed_rows[i].key, directed_rows[i].rd);
      if (directed_rows[i].typed) pending_lookups[$] = directed_rows[i].want;
    end

    tally_random = 1'b1;
    while (random_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) transact(REQ_CLEAR, rand_offset(), rand_index());
      if ($urandom_range(0, 19) == 0) n = 0;
      else if ($urandom_range(0, 9) == 0) n = $urandom_range(40, 200);
      else n = $urandom_range(1, 24);
      append_run(n);
      query_burst($urandom_range(4, 30));
    end
    start <= 1'b0;

    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d transactions (%0d directed, %0d random), checked %0d results.",
             sent_total, directed_rows.size(), random_sent, results_seen);
    $display("Table peaked at %0d entries; %0d appends refused on a full table; %0d mismatches.",
             peak_total, full_rejects, mismatches);
    if (mismatches == 0 && pending_lookups.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timed out with %0d results still pending.", pending_lookups.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
